FILE: src/tpi_pkg.sv
// Package for the trapezoid polynomial integrator: sizes, register and status
// codes, sequencer states.
// No dependencies; used by trapezoid_poly_integrator.
package tpi_pkg;

    // Polynomial storage
    localparam int MAX_DEGREE = 4;
    localparam int NUM_COEF   = MAX_DEGREE + 1;
    localparam int COEF_IDX_W = (NUM_COEF > 1) ? $clog2(NUM_COEF) : 1;
    // Horner step counter holds 0..MAX_DEGREE+1
    localparam int K_W        = $clog2(MAX_DEGREE + 2);

    // Field widths
    localparam int BOUND_W    = 32;
    localparam int COEF_W     = 32;
    localparam int INTV_W     = 12;
    localparam int DEG_W      = 3;
    localparam int ACC_W      = 48;
    localparam int STATUS_W   = 2;

    // Shared multiplier datapath
    localparam int MA_W       = ACC_W + 1;          // magnitude of a 49-bit sum
    localparam int MB_W       = 32;
    localparam int MHI_W      = MA_W - 32;          // upper slice of operand A
    localparam int PROD_W     = MA_W + MB_W;
    localparam int SHIFT_PT   = 16;                 // Horner rescale
    localparam int SHIFT_AREA = 17;                 // rescale plus halving

    // Divider: one quotient bit per cycle over the bound difference magnitude
    localparam int DIV_STEPS  = 32;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Stream packing
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 56;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_LAST = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd2;

    // Saturation limits of the 48-bit accumulators
    localparam logic [ACC_W-1:0] MAX48 = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] MIN48 = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_PT_INIT,
        S_HSTEP,
        S_MLO,
        S_MHI,
        S_MSUM,
        S_MADD,
        S_NEXT,
        S_OUT
    } t_state;

endpackage

FILE: src/trapezoid_poly_integrator.sv
// Trapezoid-rule integrator of a configured polynomial, fixed point.
// Depends on tpi_pkg (sizes, codes, state type).
//
// Usage:
//   Config channel: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data.
//   Index 0 is the degree, 1..5 the coefficients, highest power first.
//   Other indexes are ignored. Write only while no request is in flight.
//   Input stream: one request per transfer (lower bound, upper bound,
//   interval count). Output stream: one result per request (integral,
//   status). s_axis_tready is high only while the block is idle.
//   Sequence: a zero interval count answers straight from idle. Otherwise the
//   step is found by a 32-bit restoring divider, then every point is
//   evaluated by Horner on one shared 32x32 multiplier and every interval
//   adds its area and the point step. Each multiply-accumulate on the
//   shared multiplier runs through S_MLO, S_MHI, S_MSUM and S_MADD.
//   The next request is taken only after the result transfer.
//   Reset (synchronous, active low) clears the degree and coefficients and
//   returns the sequencer to idle. When the receiver stalls, the result
//   stays on m_axis_tdata and no new request is taken.
module trapezoid_poly_integrator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tpi_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tpi_pkg::COEF_W-1:0]      i_cfg_data,
    // Request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] lower_bound, [63:32] upper_bound, [75:64] intervals, [79:76] zero
    input  logic [tpi_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // Result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [47:0] integral, [49:48] status, [55:50] zero
    output logic [tpi_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    tpi_pkg::t_state r_state, n_state;

    // Configuration registers
    logic [tpi_pkg::DEG_W-1:0]  r_degree;
    logic [tpi_pkg::COEF_W-1:0] r_coef [tpi_pkg::NUM_COEF];

    // Request and sequencing registers
    logic [tpi_pkg::BOUND_W-1:0]  r_x;
    logic [tpi_pkg::INTV_W-1:0]   r_m;
    logic [tpi_pkg::INTV_W-1:0]   r_i;
    logic [tpi_pkg::K_W-1:0]      r_d;
    logic [tpi_pkg::K_W-1:0]      r_k;
    logic                         r_first;
    logic                         r_area;
    logic                         r_sat;
    // Divider
    logic                         r_dneg;
    logic [tpi_pkg::DIV_STEPS-1:0] r_quo;
    logic [tpi_pkg::INTV_W-1:0]   r_rem;
    logic [tpi_pkg::DIV_CNT_W-1:0] r_cnt;
    // Accumulators
    logic [tpi_pkg::ACC_W-1:0]    r_acc;
    logic [tpi_pkg::ACC_W-1:0]    r_f0;
    logic [tpi_pkg::ACC_W-1:0]    r_sum;
    // Multiplier operands and partial products
    logic [tpi_pkg::MA_W-1:0]     r_ma;
    logic [tpi_pkg::MB_W-1:0]     r_mb;
    logic                         r_mneg;
    logic [63:0]                  r_pl;
    logic [63:0]                  r_ph;
    logic [tpi_pkg::MA_W-1:0]     r_mres;
    // Result
    logic [tpi_pkg::ACC_W-1:0]    r_integral;
    logic [tpi_pkg::STATUS_W-1:0] r_status;

    logic in_xfer, out_xfer, cfg_xfer;

    // Request fields
    logic [tpi_pkg::BOUND_W-1:0] in_lower, in_upper;
    logic [tpi_pkg::INTV_W-1:0]  in_intv;
    assign in_lower = s_axis_tdata[31:0];
    assign in_upper = s_axis_tdata[63:32];
    assign in_intv  = s_axis_tdata[75:64];

    assign in_xfer  = s_axis_tvalid & s_axis_tready;
    assign out_xfer = m_axis_tvalid & m_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign cfg_xfer = i_cfg_valid & o_cfg_ready;

    // Bound difference, sign and magnitude
    logic [32:0] diff, diff_mag;
    assign diff     = {in_upper[31], in_upper} - {in_lower[31], in_lower};
    assign diff_mag = diff[32] ? (33'd0 - diff) : diff;

    // Degree in use, clamped
    logic [tpi_pkg::K_W-1:0] deg_use;
    assign deg_use = (r_degree > tpi_pkg::MAX_DEGREE) ? tpi_pkg::K_W'(tpi_pkg::MAX_DEGREE)
                                                      : tpi_pkg::K_W'(r_degree);

    // Divider step
    logic [tpi_pkg::INTV_W:0] div_shift;
    logic                     div_ge;
    assign div_shift = {r_rem, r_quo[tpi_pkg::DIV_STEPS-1]};
    assign div_ge    = div_shift >= {1'b0, r_m};

    // Signed step
    logic [tpi_pkg::BOUND_W-1:0] h_val;
    assign h_val = r_dneg ? (32'd0 - r_quo) : r_quo;

    // Horner operands
    logic [tpi_pkg::MA_W-1:0] acc_mag;
    logic [tpi_pkg::MB_W-1:0] x_mag;
    assign acc_mag = r_acc[tpi_pkg::ACC_W-1] ? (49'd0 - {1'b1, r_acc}) : {1'b0, r_acc};
    assign x_mag   = r_x[31] ? (32'd0 - r_x) : r_x;

    // Area operands: s = f0 + f1 with f1 in the accumulator
    logic [tpi_pkg::MA_W-1:0] pair_sum, pair_mag;
    assign pair_sum = {r_f0[47], r_f0} + {r_acc[47], r_acc};
    assign pair_mag = pair_sum[48] ? (49'd0 - pair_sum) : pair_sum;

    // Shared multiplier: low slice first, then high slice
    logic [31:0] mul_a;
    logic [63:0] mul_p;
    assign mul_a = (r_state == tpi_pkg::S_MLO) ? r_ma[31:0]
                                               : {{(32-tpi_pkg::MHI_W){1'b0}},
                                                  r_ma[tpi_pkg::MA_W-1:32]};
    assign mul_p = mul_a * r_mb;

    // Partial product merge, rescale and clamp
    logic [tpi_pkg::PROD_W-1:0] prod, prod_sh;
    logic [tpi_pkg::ACC_W-1:0]  lim, mag_cl;
    logic                       mul_ovf;
    logic [tpi_pkg::MA_W-1:0]   mul_res;
    assign prod    = {17'd0, r_pl} + {r_ph[tpi_pkg::MA_W-1:0], 32'd0};
    assign prod_sh = r_area ? (prod >> tpi_pkg::SHIFT_AREA) : (prod >> tpi_pkg::SHIFT_PT);
    assign lim     = r_mneg ? tpi_pkg::MIN48 : tpi_pkg::MAX48;
    assign mul_ovf = (|prod_sh[tpi_pkg::PROD_W-1:tpi_pkg::ACC_W]) ||
                     (prod_sh[tpi_pkg::ACC_W-1:0] > lim);
    assign mag_cl  = mul_ovf ? lim : prod_sh[tpi_pkg::ACC_W-1:0];
    assign mul_res = r_mneg ? (49'd0 - {1'b0, mag_cl}) : {1'b0, mag_cl};

    // Accumulate with 48-bit saturation
    logic [tpi_pkg::ACC_W-1:0] add_base, add_res;
    logic [49:0]               add_full;
    logic                      add_ovf;
    logic [tpi_pkg::COEF_W-1:0] coef_k;
    assign coef_k   = r_coef[r_k[tpi_pkg::COEF_IDX_W-1:0]];
    assign add_base = r_area ? r_sum : {{(tpi_pkg::ACC_W-tpi_pkg::COEF_W){coef_k[31]}}, coef_k};
    assign add_full = {add_base[47], add_base[47], add_base} + {r_mres[48], r_mres};
    assign add_ovf  = !((add_full[49] == add_full[48]) && (add_full[48] == add_full[47]));
    assign add_res  = !add_ovf ? add_full[47:0] :
                      (add_full[49] ? tpi_pkg::MIN48 : tpi_pkg::MAX48);

    logic last_intv;
    assign last_intv = (r_i == (r_m - 12'd1));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tpi_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state = (in_intv == '0) ? tpi_pkg::S_OUT : tpi_pkg::S_DIV;
                end
            end
            tpi_pkg::S_DIV: begin
                if (r_cnt == tpi_pkg::DIV_CNT_W'(tpi_pkg::DIV_STEPS - 1)) begin
                    n_state = tpi_pkg::S_PT_INIT;
                end
            end
            tpi_pkg::S_PT_INIT: n_state = tpi_pkg::S_HSTEP;
            tpi_pkg::S_HSTEP: begin
                if ((r_k > r_d) && r_first) begin
                    n_state = tpi_pkg::S_NEXT;
                end else begin
                    n_state = tpi_pkg::S_MLO;
                end
            end
            tpi_pkg::S_MLO:  n_state = tpi_pkg::S_MHI;
            tpi_pkg::S_MHI:  n_state = tpi_pkg::S_MSUM;
            tpi_pkg::S_MSUM: n_state = tpi_pkg::S_MADD;
            tpi_pkg::S_MADD: begin
                if (r_area) begin
                    n_state = last_intv ? tpi_pkg::S_OUT : tpi_pkg::S_NEXT;
                end else begin
                    n_state = tpi_pkg::S_HSTEP;
                end
            end
            tpi_pkg::S_NEXT: n_state = tpi_pkg::S_PT_INIT;
            tpi_pkg::S_OUT: begin
                if (out_xfer) begin
                    n_state = tpi_pkg::S_IDLE;
                end
            end
            default: n_state = tpi_pkg::S_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        s_axis_tready = (r_state == tpi_pkg::S_IDLE);
        m_axis_tvalid = (r_state == tpi_pkg::S_OUT);
    end

    assign m_axis_tdata = {6'd0, r_status, r_integral};

    // State and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tpi_pkg::S_IDLE;
            r_degree <= '0;
            for (int j = 0; j < tpi_pkg::NUM_COEF; j++) begin
                r_coef[j] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (cfg_xfer) begin
                if (i_cfg_index == tpi_pkg::CFG_DEGREE) begin
                    r_degree <= i_cfg_data[tpi_pkg::DEG_W-1:0];
                end else if ((i_cfg_index >= tpi_pkg::CFG_COEF_0) &&
                             (i_cfg_index <= tpi_pkg::CFG_COEF_LAST) &&
                             (int'(i_cfg_index - tpi_pkg::CFG_COEF_0) < tpi_pkg::NUM_COEF))
                begin
                    r_coef[tpi_pkg::COEF_IDX_W'(i_cfg_index - tpi_pkg::CFG_COEF_0)]
                        <= i_cfg_data;
                end
            end
        end
    end

    // Datapath under the sequencer
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            tpi_pkg::S_IDLE: begin
                if (in_xfer) begin
                    r_x     <= in_lower;
                    r_m     <= in_intv;
                    r_d     <= deg_use;
                    r_i     <= '0;
                    r_first <= 1'b1;
                    r_sat   <= 1'b0;
                    r_sum   <= '0;
                    r_dneg  <= diff[32];
                    r_quo   <= diff_mag[31:0];
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_integral <= '0;
                    r_status   <= tpi_pkg::STATUS_ZERO;
                end
            end
            tpi_pkg::S_DIV: begin
                // One restoring quotient bit per cycle
                r_rem <= div_ge ? tpi_pkg::INTV_W'(div_shift - {1'b0, r_m})
                                : div_shift[tpi_pkg::INTV_W-1:0];
                r_quo <= {r_quo[tpi_pkg::DIV_STEPS-2:0], div_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            tpi_pkg::S_PT_INIT: begin
                r_acc <= {{(tpi_pkg::ACC_W-tpi_pkg::COEF_W){r_coef[0][31]}}, r_coef[0]};
                r_k   <= tpi_pkg::K_W'(1);
            end
            tpi_pkg::S_HSTEP: begin
                if (r_k > r_d) begin
                    // Point done: first point seeds f0, later ones start an area
                    if (r_first) begin
                        r_f0    <= r_acc;
                        r_first <= 1'b0;
                    end else begin
                        r_ma   <= pair_mag;
                        r_mb   <= r_quo;
                        r_mneg <= pair_sum[48] ^ r_dneg;
                        r_area <= 1'b1;
                    end
                end else begin
                    r_ma   <= acc_mag;
                    r_mb   <= x_mag;
                    r_mneg <= r_acc[47] ^ r_x[31];
                    r_area <= 1'b0;
                end
            end
            tpi_pkg::S_MLO: r_pl <= mul_p;
            tpi_pkg::S_MHI: r_ph <= mul_p;
            tpi_pkg::S_MSUM: begin
                r_mres <= mul_res;
                if (mul_ovf) begin
                    r_sat <= 1'b1;
                end
            end
            tpi_pkg::S_MADD: begin
                if (add_ovf) begin
                    r_sat <= 1'b1;
                end
                if (r_area) begin
                    r_sum <= add_res;
                    r_f0  <= r_acc;
                    r_i   <= r_i + 1'b1;
                    if (last_intv) begin
                        r_integral <= add_res;
                        r_status   <= (r_sat || add_ovf) ? tpi_pkg::STATUS_SAT
                                                         : tpi_pkg::STATUS_OK;
                    end
                end else begin
                    r_acc <= add_res;
                    r_k   <= r_k + 1'b1;
                end
            end
            tpi_pkg::S_NEXT: r_x <= r_x + h_val;
            tpi_pkg::S_OUT: begin
            end
            default: begin
            end
        endcase
    end

endmodule
